// ===== rtl/urf_pkg.sv =====
// Shared types and constants for the ultrasonic range finder.
package urf_pkg;

    localparam int LIMIT_W      = 10;
    localparam int TIMEOUT_W    = 20;
    localparam int DIST_W       = 17;
    localparam int WIDTH_W      = 20;
    localparam int SCALED_LIM_W = 20;
    localparam int STATUS_W     = 3;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 20;
    localparam int IN_TDATA_W   = 8;
    localparam int OUT_TDATA_W  = 48;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_TRIG  = 3'd1,
        PH_WLOW  = 3'd2,
        PH_WHIGH = 3'd3,
        PH_MEAS  = 3'd4
    } t_phase;

    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_UNDER   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_OVER    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_TIMEOUT = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ACTIVE  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_LOWER   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd2;

    localparam logic [LIMIT_W-1:0]   LOWER_RST   = 10'd2;
    localparam logic [LIMIT_W-1:0]   UPPER_RST   = 10'd400;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 20'd1000000;

    // Limits as seen by the core: cm, cm*1000 for the compare against width*17.
    typedef struct packed {
        logic [SCALED_LIM_W-1:0] lower_scaled;
        logic [SCALED_LIM_W-1:0] upper_scaled;
        logic [LIMIT_W-1:0]      lower_cm;
        logic [LIMIT_W-1:0]      upper_cm;
        logic [TIMEOUT_W-1:0]    timeout;
    } t_urf_cfg;

    typedef struct packed {
        logic [WIDTH_W-1:0]  width;
        logic [DIST_W-1:0]   distance;
        logic [STATUS_W-1:0] status;
        logic                done;
        logic                trigger;
    } t_urf_res;

    function automatic logic [SCALED_LIM_W-1:0] cm_times_1000(input logic [LIMIT_W-1:0] cm);
        logic [SCALED_LIM_W-1:0] x;
        x = {{(SCALED_LIM_W-LIMIT_W){1'b0}}, cm};
        return (x << 10) - (x << 5) + (x << 3);
    endfunction

    function automatic logic [DIST_W-1:0] cm_times_100(input logic [LIMIT_W-1:0] cm);
        logic [DIST_W-1:0] x;
        x = {{(DIST_W-LIMIT_W){1'b0}}, cm};
        return (x << 6) + (x << 5) + (x << 2);
    endfunction

endpackage

// ===== rtl/urf_core.sv =====
// Measurement sequencer: trigger pulse, echo wait, pulse timing and result formatting.
module urf_core import urf_pkg::*; #(
    parameter int TRIGGER_TICKS = 10,
    parameter int COUNT_BITS    = 20
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_step,
    input  logic     i_start,
    input  logic     i_echo,
    input  t_urf_cfg i_cfg,
    output t_urf_res o_res
);

    localparam int TW = $clog2(TRIGGER_TICKS + 1);
    localparam int QW = COUNT_BITS + 1;
    localparam int SW = COUNT_BITS + 5;

    t_phase                r_phase, n_phase;
    logic [TW-1:0]         r_tcnt, n_tcnt;
    logic [COUNT_BITS-1:0] r_elapsed, n_elapsed;
    logic [COUNT_BITS-1:0] r_pulse, n_pulse;
    logic [SW-1:0]         r_scaled, n_scaled;
    logic [QW-1:0]         r_quot, n_quot;
    logic [3:0]            r_rem, n_rem;

    logic                  trig_more;
    logic                  waiting;
    logic [COUNT_BITS-1:0] e_wait;
    logic                  fin_ok;
    logic                  tmo;
    logic [4:0]            rem_sum;

    assign trig_more = (r_tcnt < TW'(TRIGGER_TICKS));
    assign waiting   = (r_phase != PH_IDLE) && (r_phase != PH_TRIG);

    // Elapsed count after this tick; an unknown phase code forces a timeout.
    always_comb begin
        if (r_phase == PH_WLOW || r_phase == PH_WHIGH || r_phase == PH_MEAS) begin
            e_wait = (&r_elapsed) ? r_elapsed : r_elapsed + 1'b1;
        end else begin
            e_wait = '1;
        end
    end

    assign fin_ok = (r_phase == PH_MEAS) && !i_echo;
    assign tmo    = waiting && !fin_ok &&
                    (({{TIMEOUT_W{1'b0}}, e_wait} >= {{COUNT_BITS{1'b0}}, i_cfg.timeout})
                     || (&e_wait));

    // width*17/10 kept as quotient and remainder, advanced by 17 per tick.
    assign rem_sum = {1'b0, r_rem} + 5'd7;

    always_comb begin
        n_phase   = r_phase;
        n_tcnt    = r_tcnt;
        n_elapsed = r_elapsed;
        n_pulse   = r_pulse;
        n_scaled  = r_scaled;
        n_quot    = r_quot;
        n_rem     = r_rem;
        case (r_phase)
            PH_IDLE: begin
                if (i_start) begin
                    n_phase   = PH_TRIG;
                    n_tcnt    = TW'(1);
                    n_elapsed = '0;
                    n_pulse   = '0;
                    n_scaled  = '0;
                    n_quot    = '0;
                    n_rem     = '0;
                end
            end
            PH_TRIG: begin
                if (trig_more) begin
                    n_tcnt = r_tcnt + 1'b1;
                end else begin
                    n_phase   = PH_WLOW;
                    n_elapsed = '0;
                end
            end
            default: begin
                n_elapsed = e_wait;
                case (r_phase)
                    PH_WLOW: begin
                        if (!i_echo) n_phase = PH_WHIGH;
                    end
                    PH_WHIGH: begin
                        if (i_echo) begin
                            n_phase  = PH_MEAS;
                            n_pulse  = COUNT_BITS'(1);
                            n_scaled = SW'(17);
                            n_quot   = QW'(1);
                            n_rem    = 4'd7;
                        end
                    end
                    PH_MEAS: begin
                        if (!(&r_pulse)) begin
                            n_pulse  = r_pulse + 1'b1;
                            n_scaled = r_scaled + SW'(17);
                            if (rem_sum >= 5'd10) begin
                                n_quot = r_quot + QW'(2);
                                n_rem  = 4'(rem_sum - 5'd10);
                            end else begin
                                n_quot = r_quot + QW'(1);
                                n_rem  = rem_sum[3:0];
                            end
                        end
                    end
                    default: ;
                endcase
                if (fin_ok || tmo) begin
                    n_phase   = PH_IDLE;
                    n_elapsed = '0;
                    n_pulse   = '0;
                    n_scaled  = '0;
                    n_quot    = '0;
                    n_rem     = '0;
                end
            end
        endcase
    end

    always_comb begin
        logic [QW+DIST_W-1:0]         quot_ext;
        logic [COUNT_BITS+WIDTH_W-1:0] pulse_ext;
        quot_ext  = {{DIST_W{1'b0}}, r_quot};
        pulse_ext = {{WIDTH_W{1'b0}}, r_pulse};
        o_res = '0;
        o_res.trigger = ((r_phase == PH_IDLE) && i_start) || ((r_phase == PH_TRIG) && trig_more);
        if (fin_ok) begin
            o_res.done  = 1'b1;
            o_res.width = pulse_ext[WIDTH_W-1:0];
            if ({{SCALED_LIM_W{1'b0}}, r_scaled} < {{SW{1'b0}}, i_cfg.lower_scaled}) begin
                o_res.status   = ST_UNDER;
                o_res.distance = cm_times_100(i_cfg.lower_cm);
            end else if ({{SCALED_LIM_W{1'b0}}, r_scaled} >
                         {{SW{1'b0}}, i_cfg.upper_scaled}) begin
                o_res.status   = ST_OVER;
                o_res.distance = cm_times_100(i_cfg.upper_cm);
            end else begin
                o_res.status   = ST_OK;
                o_res.distance = quot_ext[DIST_W-1:0];
            end
        end else if (tmo) begin
            o_res.done   = 1'b1;
            o_res.status = ST_TIMEOUT;
        end else if (i_start && (r_phase != PH_IDLE)) begin
            o_res.done   = 1'b1;
            o_res.status = ST_ACTIVE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_tcnt    <= '0;
            r_elapsed <= '0;
            r_pulse   <= '0;
            r_scaled  <= '0;
            r_quot    <= '0;
            r_rem     <= '0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_tcnt    <= n_tcnt;
            r_elapsed <= n_elapsed;
            r_pulse   <= n_pulse;
            r_scaled  <= n_scaled;
            r_quot    <= n_quot;
            r_rem     <= n_rem;
        end
    end

endmodule

// ===== rtl/ultrasonic_range_finder.sv =====
// Top level: stream ports, configuration registers and output register.
// One input item per microsecond tick goes in, one result item comes out for
// every input item, from an output register loaded at acceptance. An item can be accepted on
// every clock: the result sits in a single output register and a new item is
// taken whenever that register is empty or is being drained the same cycle, so
// throughput is one item per clock as long as the output side keeps up. The
// distance is kept as a running width*17/10 quotient while the echo is high,
// so no multiplier or divider sits in the path. The user must write configuration
// only while no measurement is in progress; the block itself does not enforce it.
module ultrasonic_range_finder import urf_pkg::*; #(
    parameter int TRIGGER_TICKS = 10,
    parameter int COUNT_BITS    = 20
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [0] start_req, [1] echo_level
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [0] trigger_level, [1] done_res, [4:2] status, [21:5] distance_centi_cm,
    // [41:22] echo_width_us
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_urf_cfg r_cfg;
    t_urf_res core_res;
    t_urf_res r_out;
    logic     r_out_valid;
    logic     accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lower_cm     <= LOWER_RST;
            r_cfg.upper_cm     <= UPPER_RST;
            r_cfg.lower_scaled <= cm_times_1000(LOWER_RST);
            r_cfg.upper_scaled <= cm_times_1000(UPPER_RST);
            r_cfg.timeout      <= TIMEOUT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_LOWER: begin
                    r_cfg.lower_cm     <= i_cfg_data[LIMIT_W-1:0];
                    r_cfg.lower_scaled <= cm_times_1000(i_cfg_data[LIMIT_W-1:0]);
                end
                REG_UPPER: begin
                    r_cfg.upper_cm     <= i_cfg_data[LIMIT_W-1:0];
                    r_cfg.upper_scaled <= cm_times_1000(i_cfg_data[LIMIT_W-1:0]);
                end
                REG_TIMEOUT: r_cfg.timeout <= i_cfg_data[TIMEOUT_W-1:0];
                default: ;
            endcase
        end
    end

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    urf_core #(
        .TRIGGER_TICKS(TRIGGER_TICKS),
        .COUNT_BITS   (COUNT_BITS)
    ) u_core (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_step (accept),
        .i_start(s_axis_tdata[0]),
        .i_echo (s_axis_tdata[1]),
        .i_cfg  (r_cfg),
        .o_res  (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= core_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W-$bits(t_urf_res)){1'b0}}, r_out};

endmodule

// ===== tb/testbench.sv =====
// Self-checking stream testbench for the ultrasonic range finder, with a per-tick predictor.
module testbench import urf_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TRIG_TICKS     = 10;
    localparam int CNT_BITS       = 20;
    localparam logic [CNT_BITS-1:0] CNT_MAX = {CNT_BITS{1'b1}};
    localparam int RESET_CYCLES   = 9;
    localparam int IDLE_PCT       = 34;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int STALL_LIMIT    = 4000;
    localparam int END_CYCLES     = 10;
    localparam int MAX_REPORTS    = 10;
    localparam int RANDOM_ITEMS   = 100;
    localparam int RANDOM_RUNS    = 4;
    localparam int TIMEOUT_MAX    = (1 << TIMEOUT_W) - 1;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data    = '0;

    ultrasonic_range_finder #(
        .TRIGGER_TICKS(TRIG_TICKS),
        .COUNT_BITS   (CNT_BITS)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),   // [0] start_req, [1] echo_level
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        // [0] trigger_level, [1] done_res, [4:2] status, [21:5] distance_centi_cm,
        // [41:22] echo_width_us
        .m_axis_tdata (m_axis_tdata),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    // Predictor state and configuration
    t_phase                ph;
    logic [CNT_BITS-1:0]   elapsed;
    logic [CNT_BITS-1:0]   pulse;
    logic [LIMIT_W-1:0]    cfg_lower;
    logic [LIMIT_W-1:0]    cfg_upper;
    logic [TIMEOUT_W-1:0]  cfg_timeout;

    t_urf_res range_results_q[$];
    int       mismatches   = 0;
    int       items_sent   = 0;
    int       stall_cycles = 0;
    bit       gaps_on      = 1'b1;
    int       hold_seq     = 0;
    int       hold_seen    = 0;
    int       hold_left    = 0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [CNT_BITS-1:0] count_up(input logic [CNT_BITS-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

    // One tick of the ranging controller; updates the predictor state.
    function automatic t_urf_res range_step(input logic start, input logic echo);
        t_urf_res    r;
        logic        done;
        logic [63:0] scaled;
        logic [63:0] dist_calc;
        r    = '0;
        done = 1'b0;
        if (ph == PH_IDLE) begin
            if (start) begin
                ph        = PH_TRIG;
                elapsed   = CNT_BITS'(1);
                pulse     = '0;
                r.trigger = 1'b1;
            end
            return r;
        end
        if (ph == PH_TRIG) begin
            if (elapsed < TRIG_TICKS) begin
                elapsed   = elapsed + 1'b1;
                r.trigger = 1'b1;
            end else begin
                ph      = PH_WLOW;
                elapsed = '0;
            end
        end else begin
            elapsed = count_up(elapsed);
            if (ph == PH_MEAS && !echo) begin
                // pulse end wins over a timeout on the same tick
                scaled    = 64'(pulse) * 64'd17;
                dist_calc = scaled / 64'd10;
                r.status  = ST_OK;
                if (scaled < 64'(cfg_lower) * 64'd1000) begin
                    r.status  = ST_UNDER;
                    dist_calc = 64'(cfg_lower) * 64'd100;
                end else if (scaled > 64'(cfg_upper) * 64'd1000) begin
                    r.status  = ST_OVER;
                    dist_calc = 64'(cfg_upper) * 64'd100;
                end
                r.done     = 1'b1;
                r.distance = dist_calc[DIST_W-1:0];
                r.width    = pulse;
                done       = 1'b1;
            end else begin
                case (ph)
                    PH_WLOW: begin
                        if (!echo) ph = PH_WHIGH;
                    end
                    PH_WHIGH: begin
                        if (echo) begin
                            ph    = PH_MEAS;
                            pulse = CNT_BITS'(1);
                        end
                    end
                    PH_MEAS: begin
                        pulse = count_up(pulse);
                    end
                    default: begin
                        elapsed = CNT_MAX;
                    end
                endcase
                if (elapsed >= cfg_timeout || elapsed == CNT_MAX) begin
                    r.done   = 1'b1;
                    r.status = ST_TIMEOUT;
                    done     = 1'b1;
                end
            end
            if (done) begin
                ph      = PH_IDLE;
                elapsed = '0;
                pulse   = '0;
                return r;
            end
        end
        if (start) begin
            r.done   = 1'b1;
            r.status = ST_ACTIVE;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input t_urf_res e, input t_urf_res a);
        if (mismatches < MAX_REPORTS) begin
            $display("%s: exp trig=%0d done=%0d st=%0d dist=%0d width=%0d",
                     what, e.trigger, e.done, e.status, e.distance, e.width);
            $display("    got trig=%0d done=%0d st=%0d dist=%0d width=%0d",
                     a.trigger, a.done, a.status, a.distance, a.width);
        end
        mismatches++;
    endtask

    // Result checker
    always @(posedge i_clk) begin
        t_urf_res act;
        t_urf_res exp_r;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            act = m_axis_tdata[$bits(t_urf_res)-1:0];
            if (range_results_q.size() == 0) begin
                report_mismatch("unexpected result", '0, act);
            end else begin
                exp_r = range_results_q.pop_front();
                if (act.trigger !== exp_r.trigger || act.done !== exp_r.done ||
                    act.status !== exp_r.status || act.distance !== exp_r.distance ||
                    act.width !== exp_r.width)
                    report_mismatch("result mismatch", exp_r, act);
            end
        end
    end

    // Output side: random stalls plus a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left     = hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (hold_seq != hold_seen) begin
            hold_seen     = hold_seq;
            hold_left     = RX_HOLD_CYCLES - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= !(gaps_on && $urandom_range(99) < IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", stall_cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_tick(input logic start, input logic echo);
        while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W-2){1'b0}}, echo, start};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        range_results_q.push_back(range_step(start, echo));
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (range_results_q.size() != 0) @(negedge i_clk);
    endtask

    // Steer the echo so that any measurement in progress completes quickly.
    task automatic finish_measurement();
        while (ph != PH_IDLE) send_tick(1'b0, ph == PH_WHIGH);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        finish_measurement();
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_DATA_W'(val);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_LOWER:   cfg_lower   = LIMIT_W'(val);
            REG_UPPER:   cfg_upper   = LIMIT_W'(val);
            REG_TIMEOUT: cfg_timeout = TIMEOUT_W'(val);
            default: ;
        endcase
    endtask

    // Start, trigger ticks, echo high while waiting for low, echo low, pulse, pulse end.
    task automatic run_measurement(input int wait_high, input int wait_low, input int width,
                                   input int start_pct);
        send_tick(1'b1, 1'($urandom_range(1)));
        repeat (TRIG_TICKS) send_tick($urandom_range(99) < start_pct, 1'($urandom_range(1)));
        repeat (wait_high) send_tick($urandom_range(99) < start_pct, 1'b1);
        repeat (wait_low) send_tick($urandom_range(99) < start_pct, 1'b0);
        repeat (width) send_tick($urandom_range(99) < start_pct, 1'b1);
        send_tick($urandom_range(99) < start_pct, 1'b0);
        finish_measurement();
    endtask

    task automatic test_default_config();
        repeat (4) send_tick(1'b0, 1'($urandom_range(1)));
        // 118 us is just inside the default lower limit, 20 us is under it
        run_measurement(0, 1, 118, 0);
        run_measurement(1, 1, 20, 0);
    endtask

    task automatic test_range_limits();
        // 1 cm lies between 58 and 59 us
        write_reg(REG_LOWER, 1);
        write_reg(REG_UPPER, 1);
        run_measurement(0, 1, 58, 0);
        run_measurement(0, 1, 59, 0);
        write_reg(REG_LOWER, 0);
        write_reg(REG_UPPER, 0);
        run_measurement(1, 1, 1, 0);
        write_reg(REG_LOWER, 1023);
        run_measurement(0, 1, 5, 0);
        write_reg(REG_LOWER, 0);
        write_reg(REG_UPPER, 1023);
    endtask

    task automatic test_timeouts();
        write_reg(REG_TIMEOUT, 0);
        run_measurement(0, 1, 5, 0);
        write_reg(REG_TIMEOUT, 1);
        run_measurement(0, 1, 5, 0);
        write_reg(REG_TIMEOUT, 5);
        run_measurement(10, 1, 5, 0);
        write_reg(REG_TIMEOUT, 6);
        run_measurement(0, 8, 3, 0);
        write_reg(REG_TIMEOUT, 10);
        run_measurement(0, 1, 8, 0);
        write_reg(REG_TIMEOUT, 9);
        run_measurement(0, 1, 8, 0);
        write_reg(REG_TIMEOUT, 12);
        run_measurement(0, 2, 15, 0);
        write_reg(REG_TIMEOUT, TIMEOUT_MAX);
        run_measurement(3, 3, 10, 0);
    endtask

    task automatic test_start_while_busy();
        write_reg(REG_LOWER, 1);
        write_reg(REG_UPPER, 3);
        write_reg(REG_TIMEOUT, 1000);
        run_measurement(2, 3, 12, 100);
        run_measurement(1, 2, 15, 50);
        write_reg(REG_TIMEOUT, 8);
        run_measurement(20, 1, 5, 100);
    endtask

    task automatic test_backpressure();
        write_reg(REG_LOWER, 1);
        write_reg(REG_UPPER, 3);
        write_reg(REG_TIMEOUT, 5000);
        hold_seq++;
        repeat (2) run_measurement(1, 2, $urandom_range(5, 20), 10);
        drain_results();
        gaps_on = 1'b0;
        repeat (3) run_measurement($urandom_range(0, 3), $urandom_range(1, 4),
                                   $urandom_range(10, 40), 5);
        gaps_on = 1'b1;
    endtask

    task automatic test_random_ranging();
        int first_item;
        int runs;
        int lo;
        first_item = items_sent;
        runs       = 0;
        while (items_sent - first_item < RANDOM_ITEMS || runs < RANDOM_RUNS) begin
            lo = $urandom_range(0, 3);
            write_reg(REG_LOWER, lo);
            write_reg(REG_UPPER, ($urandom_range(3) == 0) ? $urandom_range(0, 1023)
                                                          : $urandom_range(lo, 5));
            write_reg(REG_TIMEOUT, ($urandom_range(2) == 0) ? $urandom_range(20, 300)
                                                            : $urandom_range(1000, TIMEOUT_MAX));
            repeat (4) begin
                if ($urandom_range(99) < 80) begin
                    run_measurement($urandom_range(0, 4), $urandom_range(1, 6),
                                    ($urandom_range(99) < 60) ? $urandom_range(1, 20)
                                                              : $urandom_range(20, 80),
                                    $urandom_range(0, 5));
                    runs++;
                end else begin
                    // noise: arbitrary start and echo levels, then let it settle
                    repeat ($urandom_range(3, 30))
                        send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
                    finish_measurement();
                end
            end
        end
    endtask

    initial begin
        ph          = PH_IDLE;
        elapsed     = '0;
        pulse       = '0;
        cfg_lower   = LOWER_RST;
        cfg_upper   = UPPER_RST;
        cfg_timeout = TIMEOUT_RST;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_default_config();
        test_range_limits();
        test_timeouts();
        test_start_while_busy();
        test_backpressure();
        test_random_ranging();

        finish_measurement();
        drain_results();
        repeat (END_CYCLES) @(posedge i_clk);
        if (range_results_q.size() != 0) begin
            $display("%0d results never arrived", range_results_q.size());
            mismatches += range_results_q.size();
        end
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/urf_pkg.sv
rtl/urf_core.sv
rtl/ultrasonic_range_finder.sv
tb/testbench.sv
